// File: hw/rtl/dpfe_pkg.sv
// Package for the disk packet frame encoder.
// Transaction payload types, framing constants and the job descriptor.
// No dependencies.
package dpfe_pkg;

  localparam int GROUP_SIZE  = 7;
  localparam int MAX_GROUPS  = 127;
  localparam int MAX_LENGTH  = MAX_GROUPS * GROUP_SIZE + GROUP_SIZE - 1;
  localparam int FIXED_BYTES = 17;
  localparam int SYNC_BYTES  = 6;
  localparam int HDR_BYTES   = 7;
  localparam int CLOSE_BYTES = 3;
  localparam int JOB_BYTES   = FIXED_BYTES;
  localparam int JOB_IDX_W   = $clog2(JOB_BYTES);
  localparam int CNT_W       = $clog2(GROUP_SIZE + 1);

  // reciprocal of the group size, exact for every saturated length
  localparam int DIV_RECIP = 2341;
  localparam int DIV_SHIFT = 14;

  localparam logic [7:0] BEGIN_BYTE = 8'hC3;
  localparam logic [7:0] END_BYTE   = 8'hC8;
  localparam logic [7:0] TOP_BIT    = 8'h80;
  localparam logic [7:0] TYPE_OTHER = 8'h7F;
  localparam logic [7:0] EXT_BIT    = 8'h40;
  localparam logic [7:0] CK_FILL    = 8'hAA;
  localparam logic [7:0] CK_MASK    = 8'h55;

  localparam logic [SYNC_BYTES-1:0][7:0] SYNC_SEQ = {
    8'hFF, 8'hFC, 8'hF3, 8'hCF, 8'h3F, 8'hFF
  };

  localparam logic REG_SOURCE_UNIT = 1'b0;
  localparam logic REG_FRAME_LIMIT = 1'b1;

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_CONTENT = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [1:0] pkt_kind;
    logic       extended_flag;
    logic [6:0] status_code;
    logic [9:0] content_length;
    logic [7:0] content_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_flag;
    logic       overflow_flag;
  } out_item_t;

  // burst of bytes handed from the framing stage to the byte sequencer
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_IDX_W-1:0]      last_idx;
    logic                      close;
    logic                      ovf;
  } job_t;

endpackage

// File: hw/rtl/disk_packet_frame_encoder.sv
// Disk packet frame encoder, top level: config registers, framing stage, byte sequencer.
// Each transaction is registered in the framing stage, its burst is loaded into the
// byte sequencer and sent out through the single output register. Throughput: one
// output byte per cycle while out_ready allows; a begin emits 14 bytes (17 for an
// empty packet, 1 on overflow), a finished group 1+n (+3 when it closes the frame).
// Reset (synchronous, rst high): no frame open, buffers empty, source_unit 0, limit 2047.
module disk_packet_frame_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dpfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dpfe_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data
);
  import dpfe_pkg::*;

  logic [6:0]  source_unit;
  logic [10:0] frame_limit;
  logic        job_load, job_free;
  job_t        job;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_unit <= 7'd0;
      frame_limit <= 11'd2047;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_UNIT: source_unit <= cfg_data[6:0];
        REG_FRAME_LIMIT: frame_limit <= cfg_data;
      endcase
    end
  end

  dpfe_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .source_unit (source_unit),
    .frame_limit (frame_limit),
    .job_free    (job_free),
    .job_load    (job_load),
    .job         (job)
  );

  dpfe_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job_in    (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/dpfe_core.sv
// Framing stage: input register, frame state, group buffer and checksum.
// Turns each transaction into a byte burst for dpfe_emit. Uses dpfe_pkg.
module dpfe_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpfe_pkg::in_item_t in_data,
  input  logic [6:0]         source_unit,
  input  logic [10:0]        frame_limit,
  input  logic               job_free,
  output logic               job_load,
  output dpfe_pkg::job_t     job
);
  import dpfe_pkg::*;

  logic     hold_valid;
  in_item_t hold;

  logic             frame_open, frame_open_next;
  logic             frame_aborted, frame_aborted_next;
  logic [2:0]       odd_left, odd_left_next;
  logic [6:0]       groups_left, groups_left_next;
  logic [CNT_W-1:0] pending_count, pending_count_next;
  logic [7:0]       running_checksum, running_checksum_next;
  logic [GROUP_SIZE-1:0][7:0] pending_bytes;

  logic       emits, advance, store_byte;
  logic [9:0] len_sat;
  logic [21:0] quot_prod;
  logic [6:0] grp;
  logic [9:0] grp_x7;
  logic [2:0] odd;
  logic [10:0] total;
  logic [7:0] type_code, ck, c0, c1, msbs;
  logic [HDR_BYTES-1:0][7:0] hdr;
  logic [GROUP_SIZE-1:0][7:0] view;
  logic [CNT_W-1:0] count_inc, target;
  logic       closes;

  assign advance  = hold_valid && (!emits || job_free);
  assign in_ready = !hold_valid || advance;
  assign job_load = advance && emits;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

  always_comb begin
    len_sat   = (hold.content_length > 10'(MAX_LENGTH)) ? 10'(MAX_LENGTH)
                                                        : hold.content_length;
    quot_prod = 22'(len_sat) * 22'(DIV_RECIP);
    grp       = quot_prod[DIV_SHIFT+6:DIV_SHIFT];
    grp_x7    = {grp, 3'b000} - {3'b000, grp};
    odd       = 3'(len_sat - grp_x7);
    total     = 11'(FIXED_BYTES) + ((odd != 3'd0) ? 11'(odd) + 11'd1 : 11'd0)
                + {1'b0, grp, 3'b000};
    type_code = (hold.pkt_kind == 2'd3) ? TYPE_OTHER : {6'd0, hold.pkt_kind};

    hdr[0] = TOP_BIT;
    hdr[1] = TOP_BIT | {1'b0, source_unit};
    hdr[2] = TOP_BIT | type_code;
    hdr[3] = TOP_BIT | (hold.extended_flag ? EXT_BIT : 8'h00);
    hdr[4] = TOP_BIT | {1'b0, hold.status_code};
    hdr[5] = TOP_BIT | {5'd0, odd};
    hdr[6] = TOP_BIT | {1'b0, grp};

    count_inc = pending_count + CNT_W'(1);
    target    = (odd_left != 3'd0) ? CNT_W'(odd_left) : CNT_W'(GROUP_SIZE);
    for (int i = 0; i < GROUP_SIZE; i++) begin
      view[i] = (CNT_W'(i) == pending_count) ? hold.content_byte : pending_bytes[i];
    end

    frame_open_next       = frame_open;
    frame_aborted_next    = frame_aborted;
    odd_left_next         = odd_left;
    groups_left_next      = groups_left;
    pending_count_next    = pending_count;
    running_checksum_next = running_checksum;
    emits      = 1'b0;
    store_byte = 1'b0;
    closes     = 1'b0;
    ck         = 8'h00;
    c0         = 8'h00;
    c1         = 8'h00;
    msbs       = 8'h00;
    job        = '0;

    unique case (hold.operation)
      OP_BEGIN: begin
        emits              = 1'b1;
        frame_open_next    = 1'b0;
        pending_count_next = '0;
        odd_left_next      = '0;
        groups_left_next   = '0;
        if (total > frame_limit) begin
          frame_aborted_next    = 1'b1;
          running_checksum_next = 8'h00;
          job.ovf               = 1'b1;
          job.last_idx          = '0;
        end else begin
          frame_aborted_next = 1'b0;
          for (int i = 0; i < HDR_BYTES; i++) begin
            ck = ck ^ hdr[i];
          end
          running_checksum_next = ck;
          odd_left_next         = odd;
          groups_left_next      = grp;
          closes                = (odd == 3'd0) && (grp == 7'd0);
          frame_open_next       = !closes;
          for (int i = 0; i < SYNC_BYTES; i++) begin
            job.bytes[i] = SYNC_SEQ[i];
          end
          job.bytes[SYNC_BYTES] = BEGIN_BYTE;
          for (int i = 0; i < HDR_BYTES; i++) begin
            job.bytes[SYNC_BYTES+1+i] = hdr[i];
          end
          job.close    = closes;
          job.last_idx = closes ? JOB_IDX_W'(JOB_BYTES - 1)
                                : JOB_IDX_W'(SYNC_BYTES + HDR_BYTES);
        end
      end
      OP_CONTENT: begin
        if (frame_open && !frame_aborted) begin
          store_byte         = 1'b1;
          pending_count_next = count_inc;
          if (count_inc >= target) begin
            emits              = 1'b1;
            pending_count_next = '0;
            ck = running_checksum;
            for (int i = 0; i < GROUP_SIZE; i++) begin
              if (CNT_W'(i) < target) begin
                ck = ck ^ view[i];
                msbs[GROUP_SIZE-1-i] = view[i][7];
              end
            end
            running_checksum_next = ck;
            if (odd_left != 3'd0) begin
              odd_left_next = 3'd0;
            end else if (groups_left != 7'd0) begin
              groups_left_next = groups_left - 7'd1;
            end
            closes          = (odd_left_next == 3'd0) && (groups_left_next == 7'd0);
            frame_open_next = !closes;
          end
        end
        c0 = CK_FILL | (ck & CK_MASK);
        c1 = CK_FILL | ({1'b0, ck[7:1]} & CK_MASK);
        job.bytes[0] = TOP_BIT | msbs;
        for (int k = 1; k < JOB_BYTES; k++) begin
          if (JOB_IDX_W'(k) <= JOB_IDX_W'(target)) begin
            job.bytes[k] = TOP_BIT | view[(k - 1) % GROUP_SIZE];
          end else if (JOB_IDX_W'(k) == JOB_IDX_W'(target) + JOB_IDX_W'(1)) begin
            job.bytes[k] = c0;
          end else if (JOB_IDX_W'(k) == JOB_IDX_W'(target) + JOB_IDX_W'(2)) begin
            job.bytes[k] = c1;
          end else if (JOB_IDX_W'(k) == JOB_IDX_W'(target) + JOB_IDX_W'(3)) begin
            job.bytes[k] = END_BYTE;
          end
        end
        job.close    = closes;
        job.last_idx = JOB_IDX_W'(target) + (closes ? JOB_IDX_W'(CLOSE_BYTES) : '0);
      end
    endcase

    // the closing trio of an empty packet uses the header checksum
    if (hold.operation == OP_BEGIN && closes) begin
      job.bytes[SYNC_BYTES+HDR_BYTES+1] = CK_FILL | (ck & CK_MASK);
      job.bytes[SYNC_BYTES+HDR_BYTES+2] = CK_FILL | ({1'b0, ck[7:1]} & CK_MASK);
      job.bytes[SYNC_BYTES+HDR_BYTES+3] = END_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open       <= 1'b0;
      frame_aborted    <= 1'b0;
      odd_left         <= '0;
      groups_left      <= '0;
      pending_count    <= '0;
      running_checksum <= '0;
    end else if (advance) begin
      frame_open       <= frame_open_next;
      frame_aborted    <= frame_aborted_next;
      odd_left         <= odd_left_next;
      groups_left      <= groups_left_next;
      pending_count    <= pending_count_next;
      running_checksum <= running_checksum_next;
    end
    if (advance && store_byte && pending_count < CNT_W'(GROUP_SIZE)) begin
      pending_bytes[pending_count[$clog2(GROUP_SIZE)-1:0]] <= hold.content_byte;
    end
  end

endmodule

// File: hw/rtl/dpfe_emit.sv
// Byte sequencer: holds one burst and moves it out a byte per cycle while
// out_ready allows, through the output register. Uses dpfe_pkg.
module dpfe_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_load,
  input  dpfe_pkg::job_t      job_in,
  output logic                job_free,
  output logic                out_valid,
  input  logic                out_ready,
  output dpfe_pkg::out_item_t out_data
);
  import dpfe_pkg::*;

  logic                 job_valid;
  job_t                 job;
  logic [JOB_IDX_W-1:0] idx;
  logic                 move, at_end;

  assign move     = job_valid && (!out_valid || out_ready);
  assign at_end   = (idx == job.last_idx);
  assign job_free = !job_valid || (move && at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (job_load) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (move) begin
      if (at_end) begin
        job_valid <= 1'b0;
      end else begin
        idx <= idx + JOB_IDX_W'(1);
      end
    end
    if (job_load) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      out_data.frame_byte    <= job.ovf ? 8'h00 : job.bytes[idx];
      out_data.last_flag     <= at_end && (job.close || job.ovf);
      out_data.overflow_flag <= job.ovf;
    end
  end

endmodule
